// ----- hw/rtl/alpha_blend_blitter_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef ALPHA_BLEND_BLITTER_DEFINES_SVH
`define ALPHA_BLEND_BLITTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ABB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/abb_pkg.sv -----
package abb_pkg;

	// Request kinds carried on the input tuser.
	typedef enum logic [1:0] {
		REQ_LOAD_SRC = 2'd0,
		REQ_LOAD_DST = 2'd1,
		REQ_READ_DST = 2'd2,
		REQ_BLIT     = 2'd3
	} req_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_SRC_WIDTH  = 2'd0,
		REG_SRC_HEIGHT = 2'd1,
		REG_DST_WIDTH  = 2'd2,
		REG_DST_HEIGHT = 2'd3
	} reg_idx_t;

	// Sequencer states.
	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_RDOUT  = 11'b000_0000_0010,
		ST_YSET   = 11'b000_0000_0100,
		ST_XSET   = 11'b000_0000_1000,
		ST_DIV    = 11'b000_0001_0000,
		ST_FETCH  = 11'b000_0010_0000,
		ST_LOADPX = 11'b000_0100_0000,
		ST_CHA    = 11'b000_1000_0000,
		ST_CHB    = 11'b001_0000_0000,
		ST_WRITE  = 11'b010_0000_0000,
		ST_SPARE  = 11'b100_0000_0000
	} state_t;

	// What the shared divider is working on.
	typedef enum logic [1:0] {
		DK_ROW  = 2'd0,
		DK_COL  = 2'd1,
		DK_CHAN = 2'd2
	} div_kind_t;

	// Side of both square pixel stores.
	localparam int MAX_DIM   = 256;

	localparam int S_TDATA_W = 104;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 32;
	localparam int M_TUSER_W = 1;
	localparam int DIM_W     = 9;
	localparam int DIV_W     = 26;
	localparam int QUO_W     = 9;

endpackage

// ----- hw/rtl/alpha_blend_blitter.sv -----
// Channel  | Dir | Handshake          | Contents
// s_*      | in  | s_tvalid/s_tready  | request word, kind on tuser
// m_*      | out | m_tvalid/m_tready  | result word, accepted flag on tuser
// cfg_*    | in  | cfg_we             | image size registers
//
// Loads, rejected reads and rejected or empty blits are answered from idle; a valid read goes through ST_RDOUT.
// In a blit, each pixel runs the one shared
// nine-step restoring divider for its column and for three colors; alpha comes from a
// reciprocal multiply. A pixel whose blended alpha sum is zero skips the color divides.
// Reset clears control and sets the size registers to 256; the pixel stores are not cleared.
// A new request is taken only in idle with the result register free or draining.
module alpha_blend_blitter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// pos_x, pos_y, pixel_in, src_x, src_y, src_w, src_h, dst_w, dst_h, tile_mode
	input  logic [abb_pkg::S_TDATA_W-1:0]   s_tdata,
	// req_type
	input  logic [abb_pkg::S_TUSER_W-1:0]   s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pixel_out
	output logic [abb_pkg::M_TDATA_W-1:0]   m_tdata,
	// accepted
	output logic [abb_pkg::M_TUSER_W-1:0]   m_tuser,
	input  logic                            cfg_we,
	input  logic [1:0]                      cfg_index,
	input  logic [abb_pkg::DIM_W-1:0]       cfg_data
);
	import abb_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [AW-1:0] pix_addr(logic [8:0] r, logic [8:0] c);
		return AW'(r) * AW'(MAX_DIM) + AW'(c);
	endfunction

	function automatic logic [8:0] eff(logic [8:0] v);
		return (int'(v) > MAX_DIM) ? 9'(MAX_DIM) : v;
	endfunction

	// Unpack the request word.
	logic [7:0]  in_px, in_py, in_sx, in_sy;
	logic [31:0] in_pix;
	logic [8:0]  in_sw, in_sh, in_dw, in_dh;
	logic        in_tile;
	req_t        in_req;
	assign in_px   = s_tdata[7:0];
	assign in_py   = s_tdata[15:8];
	assign in_pix  = s_tdata[47:16];
	assign in_sx   = s_tdata[55:48];
	assign in_sy   = s_tdata[63:56];
	assign in_sw   = s_tdata[72:64];
	assign in_sh   = s_tdata[81:73];
	assign in_dw   = s_tdata[90:82];
	assign in_dh   = s_tdata[99:91];
	assign in_tile = s_tdata[100];
	assign in_req  = req_t'(s_tuser);

	logic [8:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
	logic [8:0] sw_eff, sh_eff, dw_eff, dh_eff;
	assign sw_eff = eff(src_width_q);
	assign sh_eff = eff(src_height_q);
	assign dw_eff = eff(dst_width_q);
	assign dh_eff = eff(dst_height_q);

	state_t      state_q;
	div_kind_t   div_kind_q;
	logic        m_valid_q, m_acc_q;
	logic [31:0] m_pix_q;
	logic [7:0]  px_q, py_q, sx_q, sy_q, dx_q, dy_q;
	logic [8:0]  sw_q, sh_q, dw_q, dh_q, ry_q, rx_q;
	logic        tile_q;
	logic [1:0]  k_q;
	logic [16:0] n_q;
	logic [15:0] pa_q, pb_q;
	logic [31:0] res_q;
	logic [AW-1:0] di_q;
	logic [DIV_W-1:0] div_rem_q, div_sh_q;
	logic [QUO_W-1:0] div_quo_q;
	logic [3:0]  div_cnt_q;
	logic [31:0] src_rd_q, dst_rd_q;

	logic accept;
	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_pix_q;
	assign m_tuser  = m_acc_q;

	// Request checks.
	logic src_pos_ok, dst_pos_ok, blit_ok, blit_empty;
	assign src_pos_ok = ({1'b0, in_px} < sw_eff) && ({1'b0, in_py} < sh_eff);
	assign dst_pos_ok = ({1'b0, in_px} < dw_eff) && ({1'b0, in_py} < dh_eff);
	assign blit_ok = (in_sw != 9'd0) && (in_sh != 9'd0) &&
		({2'b0, in_sx} + {1'b0, in_sw} <= {1'b0, sw_eff}) &&
		({2'b0, in_sy} + {1'b0, in_sh} <= {1'b0, sh_eff}) &&
		({2'b0, in_px} + {1'b0, in_dw} <= {1'b0, dw_eff}) &&
		({2'b0, in_py} + {1'b0, in_dh} <= {1'b0, dh_eff});
	assign blit_empty = (in_dw == 9'd0) || (in_dh == 9'd0);

	// Blend operands straight from the read registers.
	logic [7:0] sa, da, sc, dc, inv_sa;
	assign sa     = src_rd_q[31:24];
	assign da     = dst_rd_q[31:24];
	assign inv_sa = 8'd255 - sa;
	assign sc     = src_rd_q[8*k_q +: 8];
	assign dc     = dst_rd_q[8*k_q +: 8];

	logic [16:0] n_next;
	assign n_next = ({1'b0, sa, 8'd0} - {9'd0, sa}) + 17'({8'd0, da} * {8'd0, inv_sa});

	logic [24:0] num_sum;
	assign num_sum = ({1'b0, pa_q, 8'd0} - {9'd0, pa_q}) + 25'({8'd0, pb_q} * {16'd0, inv_sa});

	// Blended alpha: floor((n + 127) / 255) by reciprocal multiply.
	logic [15:0] a_y;
	logic [31:0] a_prod;
	logic [7:0]  a_val;
	assign a_y    = 16'(n_q + 17'd127);
	assign a_prod = {16'd0, a_y} * 32'h0000_8081;
	assign a_val  = a_prod[30:23];

	// Divider step and finished quotient.
	logic             div_ge;
	logic [7:0]       chan_val;
	assign div_ge   = (div_rem_q >= div_sh_q);
	assign chan_val = (div_quo_q > 9'd255) ? 8'd255 : div_quo_q[7:0];

	logic [QUO_W-1:0] quo_fin;
	logic [8:0]       rem_fin, coord_off;
	assign quo_fin   = {div_quo_q[7:0], div_ge};
	assign rem_fin   = div_ge ? 9'(div_rem_q - div_sh_q) : div_rem_q[8:0];
	assign coord_off = tile_q ? rem_fin : quo_fin;

	// Memory port controls.
	logic          src_we, src_re, dst_we, dst_re;
	logic [AW-1:0] src_waddr, src_raddr, dst_waddr, dst_raddr;
	logic [31:0]   dst_wdata;
	logic [8:0]    dst_row, dst_col;
	assign dst_row = {1'b0, py_q} + {1'b0, dy_q};
	assign dst_col = {1'b0, px_q} + {1'b0, dx_q};

	always_comb begin
		src_we    = accept && (in_req == REQ_LOAD_SRC) && src_pos_ok;
		src_waddr = pix_addr({1'b0, in_py}, {1'b0, in_px});
		src_re    = (state_q == ST_FETCH);
		src_raddr = pix_addr(ry_q, rx_q);
		dst_we    = 1'b0;
		dst_waddr = pix_addr({1'b0, in_py}, {1'b0, in_px});
		dst_wdata = in_pix;
		if (accept && (in_req == REQ_LOAD_DST) && dst_pos_ok) begin
			dst_we = 1'b1;
		end else if (state_q == ST_WRITE) begin
			dst_we    = 1'b1;
			dst_waddr = di_q;
			dst_wdata = res_q;
		end
		dst_re    = 1'b0;
		dst_raddr = pix_addr({1'b0, in_py}, {1'b0, in_px});
		if (accept && (in_req == REQ_READ_DST) && dst_pos_ok) begin
			dst_re = 1'b1;
		end else if (state_q == ST_FETCH) begin
			dst_re    = 1'b1;
			dst_raddr = pix_addr(dst_row, dst_col);
		end
	end

	// Pixel stores.
	logic [31:0] src_mem [DEPTH];
	logic [31:0] dst_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (src_we) src_mem[src_waddr] <= in_pix;
		if (src_re) src_rd_q <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (dst_we) dst_mem[dst_waddr] <= dst_wdata;
		if (dst_re) dst_rd_q <= dst_mem[dst_raddr];
	end

	// Size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= 9'd256;
			src_height_q <= 9'd256;
			dst_width_q  <= 9'd256;
			dst_height_q <= 9'd256;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				REG_SRC_HEIGHT: src_height_q <= cfg_data;
				REG_DST_WIDTH:  dst_width_q  <= cfg_data;
				REG_DST_HEIGHT: dst_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_valid_q  <= 1'b0;
			div_kind_q <= DK_ROW;
			div_cnt_q  <= 4'd0;
			k_q        <= 2'd0;
		end else begin
			if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_req)
							REQ_LOAD_SRC: m_valid_q <= 1'b1;
							REQ_LOAD_DST: m_valid_q <= 1'b1;
							REQ_READ_DST: begin
								if (dst_pos_ok) state_q   <= ST_RDOUT;
								else            m_valid_q <= 1'b1;
							end
							REQ_BLIT: begin
								if (blit_ok && !blit_empty) state_q   <= ST_YSET;
								else                        m_valid_q <= 1'b1;
							end
							default: ;
						endcase
					end
				end
				ST_RDOUT: begin
					m_valid_q <= 1'b1;
					state_q   <= ST_IDLE;
				end
				ST_YSET: begin
					div_kind_q <= DK_ROW;
					div_cnt_q  <= 4'd8;
					state_q    <= ST_DIV;
				end
				ST_XSET: begin
					div_kind_q <= DK_COL;
					div_cnt_q  <= 4'd8;
					state_q    <= ST_DIV;
				end
				ST_DIV: begin
					if (div_cnt_q != 4'd0) begin
						div_cnt_q <= div_cnt_q - 4'd1;
					end else begin
						unique case (div_kind_q)
							DK_ROW:  state_q <= ST_XSET;
							DK_COL:  state_q <= ST_FETCH;
							DK_CHAN: begin
								if (k_q == 2'd2) begin
									state_q <= ST_WRITE;
								end else begin
									k_q     <= k_q + 2'd1;
									state_q <= ST_CHA;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_FETCH: state_q <= ST_LOADPX;
				ST_LOADPX: begin
					k_q     <= 2'd0;
					state_q <= (n_next == 17'd0) ? ST_WRITE : ST_CHA;
				end
				ST_CHA: state_q <= ST_CHB;
				ST_CHB: begin
					div_kind_q <= DK_CHAN;
					div_cnt_q  <= 4'd8;
					state_q    <= ST_DIV;
				end
				ST_WRITE: begin
					if ({1'b0, dx_q} + 9'd1 < dw_q) begin
						state_q <= ST_XSET;
					end else if ({1'b0, dy_q} + 9'd1 < dh_q) begin
						state_q <= ST_YSET;
					end else begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					px_q   <= in_px;
					py_q   <= in_py;
					sx_q   <= in_sx;
					sy_q   <= in_sy;
					sw_q   <= in_sw;
					sh_q   <= in_sh;
					dw_q   <= in_dw;
					dh_q   <= in_dh;
					tile_q <= in_tile;
					dx_q   <= 8'd0;
					dy_q   <= 8'd0;
					m_pix_q <= 32'd0;
					unique case (in_req)
						REQ_LOAD_SRC: m_acc_q <= src_pos_ok;
						REQ_LOAD_DST: m_acc_q <= dst_pos_ok;
						REQ_READ_DST: m_acc_q <= dst_pos_ok;
						REQ_BLIT:     m_acc_q <= blit_ok;
						default:      m_acc_q <= 1'b0;
					endcase
				end
			end
			ST_RDOUT: begin
				m_pix_q <= dst_rd_q;
				m_acc_q <= 1'b1;
			end
			ST_YSET: begin
				div_rem_q <= tile_q ? DIV_W'(dy_q) : DIV_W'(17'({9'd0, dy_q} * {8'd0, sh_q}));
				div_sh_q  <= tile_q ? DIV_W'({sh_q, 8'd0}) : DIV_W'({dh_q, 8'd0});
				div_quo_q <= '0;
			end
			ST_XSET: begin
				div_rem_q <= tile_q ? DIV_W'(dx_q) : DIV_W'(17'({9'd0, dx_q} * {8'd0, sw_q}));
				div_sh_q  <= tile_q ? DIV_W'({sw_q, 8'd0}) : DIV_W'({dw_q, 8'd0});
				div_quo_q <= '0;
			end
			ST_DIV: begin
				if (div_ge) div_rem_q <= div_rem_q - div_sh_q;
				div_sh_q  <= div_sh_q >> 1;
				div_quo_q <= quo_fin;
				if (div_cnt_q == 4'd0) begin
					unique case (div_kind_q)
						DK_ROW:  ry_q <= {1'b0, sy_q} + coord_off;
						DK_COL:  rx_q <= {1'b0, sx_q} + coord_off;
						DK_CHAN: res_q[8*k_q +: 8] <= (quo_fin > 9'd255) ? 8'd255 : quo_fin[7:0];
						default: ;
					endcase
				end
			end
			ST_FETCH: di_q <= pix_addr(dst_row, dst_col);
			ST_LOADPX: begin
				n_q   <= n_next;
				res_q <= 32'd0;
			end
			ST_CHA: begin
				pa_q <= {8'd0, sc} * {8'd0, sa};
				pb_q <= {8'd0, dc} * {8'd0, da};
				if (k_q == 2'd0) res_q[31:24] <= a_val;
			end
			ST_CHB: begin
				div_rem_q <= {num_sum, 1'b0} + DIV_W'(n_q);
				div_sh_q  <= DIV_W'({n_q[15:0], 1'b0, 8'd0});
				div_quo_q <= '0;
			end
			ST_WRITE: begin
				if ({1'b0, dx_q} + 9'd1 < dw_q) begin
					dx_q <= dx_q + 8'd1;
				end else begin
					dx_q <= 8'd0;
					dy_q <= dy_q + 8'd1;
					m_pix_q <= 32'd0;
					m_acc_q <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	logic unused_ok;
	assign unused_ok = ^{chan_val, n_q[16], s_tdata[S_TDATA_W-1:101], a_prod[31],
		a_prod[22:0]};

endmodule

// ----- hw/rtl/abb_checker.sv -----
`include "alpha_blend_blitter_defines.svh"

module abb_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic [abb_pkg::S_TDATA_W-1:0] s_tdata,
	input logic [abb_pkg::S_TUSER_W-1:0] s_tuser,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [abb_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [abb_pkg::M_TUSER_W-1:0] m_tuser,
	input logic                          cfg_we,
	input logic [1:0]                    cfg_index,
	input logic [abb_pkg::DIM_W-1:0]     cfg_data
);
	import abb_pkg::*;

	logic in_acc, is_load;
	assign in_acc  = s_tvalid && s_tready;
	assign is_load = (s_tuser == REQ_LOAD_SRC) || (s_tuser == REQ_LOAD_DST);

	// Hold a stalled result word.
	`ABB_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

	// Take no request while an untaken result sits in the output.
	`ABB_ASSERT_NOW(a_no_overrun, in_acc, !m_tvalid || m_tready, "request taken over a pending result")

	// Answer a load in the next cycle with a zero pixel.
	`ABB_ASSERT_NEXT(a_load_resp, in_acc && is_load, m_tvalid && (m_tdata == '0), "load result missing or nonzero")

endmodule

bind alpha_blend_blitter abb_checker u_abb_checker (.*);
